// File: rtl/strtl_pkg.sv
package strtl_pkg;

    // Longest group that is assembled; later vertices of a group are dropped.
    localparam int MAX_GROUP_VERTICES = 2048;

    localparam int INDEX_W  = 16;
    localparam int CORNER_W = 11;
    localparam int POS_W    = $clog2(MAX_GROUP_VERTICES + 1);
    localparam int RUN_W    = 2;

    localparam int TRI_W       = 3 * CORNER_W;
    localparam int S_TDATA_W   = ((INDEX_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((TRI_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_GROUP_VERTICES);

    localparam logic [RUN_W-1:0] RUN_NONE = 2'd0;
    localparam logic [RUN_W-1:0] RUN_ONE  = 2'd1;
    localparam logic [RUN_W-1:0] RUN_FULL = 2'd2;

    // corner_a sits in the lowest bits.
    typedef struct packed {
        logic [CORNER_W-1:0] corner_c;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_a;
    } triangle_t;

    // Low corner bits of a position, zero-extended when positions are narrow.
    function automatic logic [CORNER_W-1:0] to_corner(input logic [POS_W-1:0] v);
        logic [POS_W+CORNER_W-1:0] wide;
        wide = {{CORNER_W{1'b0}}, v};
        return wide[CORNER_W-1:0];
    endfunction

endpackage

// File: rtl/strtl_asm.sv
module strtl_asm
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [strtl_pkg::INDEX_W-1:0]    vertex_index,
    input  logic                             group_last,
    output logic                             emit,
    output strtl_pkg::triangle_t             triangle
);
    import strtl_pkg::*;

    logic [INDEX_W-1:0] previous_index_reg, previous_index_next;
    logic [RUN_W-1:0]   run_length_reg, run_length_next;
    logic [POS_W-1:0]   position_reg, position_next;

    logic               in_range;
    logic               continues;
    logic [INDEX_W:0]   index_succ;
    logic [POS_W-1:0]   pos_m1;
    logic [POS_W-1:0]   pos_m2;

    assign in_range   = position_reg < MAX_POS;
    assign index_succ = {1'b0, previous_index_reg} + {{INDEX_W{1'b0}}, 1'b1};
    // A wrap from the top index to zero does not match because of the carry bit.
    assign continues  = (run_length_reg != RUN_NONE) && ({1'b0, vertex_index} == index_succ);
    assign emit       = accept && in_range && continues && (run_length_reg == RUN_FULL);

    assign pos_m1 = position_reg - POS_W'(1);
    assign pos_m2 = position_reg - POS_W'(2);

    always_comb
    begin
        triangle.corner_a = to_corner(pos_m2);
        if (vertex_index[0])
        begin
            triangle.corner_b = to_corner(position_reg);
            triangle.corner_c = to_corner(pos_m1);
        end
        else
        begin
            triangle.corner_b = to_corner(pos_m1);
            triangle.corner_c = to_corner(position_reg);
        end
    end

    always_comb
    begin
        previous_index_next = previous_index_reg;
        run_length_next     = run_length_reg;
        position_next       = position_reg;
        if (accept)
        begin
            if (in_range)
            begin
                previous_index_next = vertex_index;
                position_next       = position_reg + POS_W'(1);
                run_length_next     = continues ? RUN_FULL : RUN_ONE;
            end
            if (group_last)
            begin
                previous_index_next = '0;
                run_length_next     = RUN_NONE;
                position_next       = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_index_reg <= '0;
            run_length_reg     <= RUN_NONE;
            position_reg       <= '0;
        end
        else
        begin
            previous_index_reg <= previous_index_next;
            run_length_reg     <= run_length_next;
            position_reg       <= position_next;
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= MAX_POS)
        else $error("position counter ran past the group limit");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && group_last |=> position_reg == '0 && run_length_reg == RUN_NONE)
        else $error("group end did not clear the assembly state");

    a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> position_reg >= POS_W'(2) && run_length_reg == RUN_FULL)
        else $error("triangle emitted without two earlier vertices in the run");

endmodule

// File: rtl/strtl_oq.sv
module strtl_oq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  strtl_pkg::triangle_t  push_data,
    output logic                  push_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output strtl_pkg::triangle_t  out_data
);
    import strtl_pkg::*;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    triangle_t out_data_reg, out_data_next;
    triangle_t skid_data_reg, skid_data_next;
    logic      pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                // The skid word moves up; no push can arrive while it is full.
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                if (push)
                begin
                    out_data_next = push_data;
                end
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a word while the output stage is empty");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("word pushed into a full output queue");

    a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> out_valid_reg && out_data_reg == $past(skid_data_reg))
        else $error("skid word was not passed to the output stage");

endmodule

// File: rtl/strip_runs_to_triangle_list_core.sv
// An emitted triangle is registered into the output register, or into the skid register if
// that one is held. Throughput: one vertex word per cycle while s_tready is high; s_tready
// drops only once the skid register holds a word of the two-word output queue.
// Reset (rst_n low, asynchronous) clears the run state, the position counter and both
// output stages; the first word after reset starts a new group.
module strip_runs_to_triangle_list_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [strtl_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] vertex_index
    input  logic                              s_tlast,   // group_last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [strtl_pkg::M_TDATA_W-1:0]   m_tdata    // [10:0] corner_a, [21:11] corner_b,
                                                         // [32:22] corner_c, rest zero
);
    import strtl_pkg::*;

    logic      accept;
    logic      emit;
    logic      queue_ready;
    triangle_t triangle;
    triangle_t out_triangle;

    assign s_tready = queue_ready;
    assign accept   = s_tvalid && queue_ready;

    strtl_asm u_asm
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .vertex_index (s_tdata[INDEX_W-1:0]),
        .group_last   (s_tlast),
        .emit         (emit),
        .triangle     (triangle)
    );

    strtl_oq u_oq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit),
        .push_data  (triangle),
        .push_ready (queue_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_triangle)
    );

    assign m_tdata = {{(M_TDATA_W - TRI_W){1'b0}}, out_triangle};

endmodule
